// File: hw/rtl/button_click_long_press_detector_core_assert.svh
// Assertion macros used by the detector core RTL.
// Needs nothing else; include it inside a module body.
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_CORE_ASSERT_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_CORE_ASSERT_SVH

// Clocked property, ignored while reset is asserted.
`define BCLP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define BCLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bclp_pkg.sv
// Types and codes for the button click / long-press detector.
// No dependencies.
package bclp_pkg;

    typedef enum logic [1:0] {
        ST_RELEASED         = 2'd0,
        ST_PRESSED          = 2'd1,
        ST_PRESSED_RELEASED = 2'd2,
        ST_LONG             = 2'd3
    } t_state;

    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_HELD          = 3'd1,
        EV_LONG          = 3'd2,
        EV_LONG_RELEASED = 3'd3,
        EV_CLICKS        = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_CLICK_WINDOW = 2'd1,
        REG_LONG_PRESS   = 2'd2,
        REG_MAX_CLICKS   = 2'd3
    } t_reg_idx;

    localparam logic [15:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [15:0] CLICK_WINDOW_RST = 16'd300;
    localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [7:0]  MAX_CLICKS_RST   = 8'd5;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] click_window_ticks;
        logic [15:0] long_press_ticks;
        logic [7:0]  max_clicks;
    } t_cfg;

    typedef struct packed {
        t_event event_code;
        t_state status;
        logic   restart_timer;
        logic   report_old_count;
    } t_decision;

endpackage

// File: hw/rtl/bclp_next.sv
// Next-state decision of the detector for one pin sample.
// Depends on bclp_pkg.
module bclp_next #(
    parameter int TIMER_WIDTH = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  bclp_pkg::t_state         i_state,
    input  logic [COUNT_WIDTH-1:0]   i_count,
    input  logic [TIMER_WIDTH-1:0]   i_elapsed,   // already advanced for this beat
    input  logic                     i_pin_level,
    input  bclp_pkg::t_cfg           i_cfg,
    output bclp_pkg::t_decision      o_dec,
    output logic [COUNT_WIDTH-1:0]   o_count
);

    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [CMP_W-1:0] elapsed_x;
    logic             past_debounce;
    logic             in_window;
    logic             long_due;
    logic             can_count;

    assign elapsed_x     = CMP_W'(i_elapsed);
    assign past_debounce = elapsed_x > CMP_W'(i_cfg.debounce_ticks);
    assign in_window     = elapsed_x <= CMP_W'(i_cfg.click_window_ticks);
    assign long_due      = elapsed_x >= CMP_W'(i_cfg.long_press_ticks);
    assign can_count     = (8'(i_count) < i_cfg.max_clicks) && (i_count != COUNT_MAX);

    always_comb begin
        o_dec.event_code       = bclp_pkg::EV_NONE;
        o_dec.status           = i_state;
        o_dec.restart_timer    = 1'b0;
        o_dec.report_old_count = 1'b0;
        o_count                = i_count;
        unique case (i_state)
            bclp_pkg::ST_PRESSED: begin
                if (i_pin_level) begin
                    if (past_debounce) begin
                        o_dec.status = bclp_pkg::ST_PRESSED_RELEASED;
                    end else begin
                        // bounce: drop the run
                        o_dec.status = bclp_pkg::ST_RELEASED;
                        o_count      = '0;
                    end
                end else if (long_due) begin
                    o_dec.status     = bclp_pkg::ST_LONG;
                    o_dec.event_code = bclp_pkg::EV_LONG;
                end else begin
                    o_dec.event_code = bclp_pkg::EV_HELD;
                end
            end
            bclp_pkg::ST_PRESSED_RELEASED: begin
                if (i_pin_level && !in_window) begin
                    o_dec.event_code       = bclp_pkg::EV_CLICKS;
                    o_dec.status           = bclp_pkg::ST_RELEASED;
                    o_dec.report_old_count = 1'b1;
                    o_count                = '0;
                end else if (!i_pin_level && in_window) begin
                    o_dec.status = bclp_pkg::ST_PRESSED;
                    if (can_count) begin
                        o_count = i_count + COUNT_WIDTH'(1);
                    end
                end
            end
            bclp_pkg::ST_LONG: begin
                if (i_pin_level) begin
                    o_dec.event_code = bclp_pkg::EV_LONG_RELEASED;
                    o_dec.status     = bclp_pkg::ST_RELEASED;
                    o_count          = '0;
                end
            end
            default: begin
                // first press of a run
                if (!i_pin_level) begin
                    o_dec.status        = bclp_pkg::ST_PRESSED;
                    o_dec.restart_timer = 1'b1;
                    o_count             = COUNT_WIDTH'(1);
                end
            end
        endcase
    end

endmodule

// File: hw/rtl/button_click_long_press_detector_core.sv
// Button click / long-press detector: state registers, APB registers, output stage.
// Depends on bclp_pkg, bclp_next and button_click_long_press_detector_core_assert.svh.
//
//  Port group   Dir  Carries
//  s_axis_*     in   one pin sample per beat (tdata[0] = pin_level)
//  m_axis_*     out  one event per beat (event_code, click_total, button_status)
//  APB p*       in   four config registers at byte addresses 0, 4, 8, 12
//
// One beat per clock unless stalled: the sample is decided and the state updated
// at the accepting edge; the result is held in the output register the next cycle.
// s_axis_tready drops only while a result waits on m_axis_tready.
// Reset (synchronous, active low) returns to released with count and timer zero
// and loads the register defaults.
module button_click_long_press_detector_core #(
    parameter int TIMER_WIDTH = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] event_code, [10:3] click_total,
                                        // [12:11] button_status, [15:13] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    bclp_pkg::t_cfg            r_cfg;
    bclp_pkg::t_state          r_state;
    logic [COUNT_WIDTH-1:0]    r_count;
    logic [TIMER_WIDTH-1:0]    r_elapsed;
    logic                      r_out_valid;
    logic [15:0]               r_out_data;

    logic [TIMER_WIDTH-1:0]    elapsed_inc;
    bclp_pkg::t_decision       dec;
    logic [COUNT_WIDTH-1:0]    n_count;
    logic [7:0]                click_total;
    logic                      in_beat;
    logic                      cfg_wr;
    bclp_pkg::t_reg_idx        reg_idx;

    assign pready        = 1'b1;
    assign reg_idx       = bclp_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign elapsed_inc   = (r_elapsed != TIMER_MAX) ? r_elapsed + TIMER_WIDTH'(1) : r_elapsed;

    bclp_next #(
        .TIMER_WIDTH(TIMER_WIDTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_next (
        .i_state     (r_state),
        .i_count     (r_count),
        .i_elapsed   (elapsed_inc),
        .i_pin_level (s_axis_tdata[0]),
        .i_cfg       (r_cfg),
        .o_dec       (dec),
        .o_count     (n_count)
    );

    assign click_total = dec.report_old_count ? 8'(r_count) : 8'(n_count);

    always_comb begin
        unique case (reg_idx)
            bclp_pkg::REG_DEBOUNCE:     prdata = {16'd0, r_cfg.debounce_ticks};
            bclp_pkg::REG_CLICK_WINDOW: prdata = {16'd0, r_cfg.click_window_ticks};
            bclp_pkg::REG_LONG_PRESS:   prdata = {16'd0, r_cfg.long_press_ticks};
            bclp_pkg::REG_MAX_CLICKS:   prdata = {24'd0, r_cfg.max_clicks};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks     <= bclp_pkg::DEBOUNCE_RST;
            r_cfg.click_window_ticks <= bclp_pkg::CLICK_WINDOW_RST;
            r_cfg.long_press_ticks   <= bclp_pkg::LONG_PRESS_RST;
            r_cfg.max_clicks         <= bclp_pkg::MAX_CLICKS_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                bclp_pkg::REG_DEBOUNCE:     r_cfg.debounce_ticks     <= pwdata[15:0];
                bclp_pkg::REG_CLICK_WINDOW: r_cfg.click_window_ticks <= pwdata[15:0];
                bclp_pkg::REG_LONG_PRESS:   r_cfg.long_press_ticks   <= pwdata[15:0];
                bclp_pkg::REG_MAX_CLICKS:   r_cfg.max_clicks         <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bclp_pkg::ST_RELEASED;
            r_count     <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_state     <= dec.status;
                r_count     <= n_count;
                r_elapsed   <= dec.restart_timer ? '0 : elapsed_inc;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: load on every accepted beat, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_data <= {3'd0, dec.status, click_total, dec.event_code};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`include "button_click_long_press_detector_core_assert.svh"

    `BCLP_ASSERT(a_released_no_count, i_clk, i_rst_n, (r_state == bclp_pkg::ST_RELEASED) |-> (r_count == '0), "count not clear while released")
    `BCLP_ASSERT(a_first_press, i_clk, i_rst_n, (in_beat && r_state == bclp_pkg::ST_RELEASED && !s_axis_tdata[0]) |=> (r_elapsed == '0 && r_state == bclp_pkg::ST_PRESSED && r_count == COUNT_WIDTH'(1)), "first press did not restart run")
    `BCLP_ASSERT(a_state_holds, i_clk, i_rst_n, (!in_beat && $past(i_rst_n)) |=> ($stable(r_state) && $stable(r_count)), "state moved without a beat")
    `BCLP_ASSERT(a_long_status, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tdata[2:0] == bclp_pkg::EV_LONG) |-> (m_axis_tdata[12:11] == bclp_pkg::ST_LONG), "long press event without long state")
    `BCLP_ASSERT(a_clicks_status, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tdata[2:0] == bclp_pkg::EV_CLICKS) |-> (m_axis_tdata[12:11] == bclp_pkg::ST_RELEASED), "click run event not released")

endmodule
